[sv/afr_pkg.sv]
// Package for the attribute frame receiver: payload structs, phase encoding,
// register indexes and reset values. No dependencies.
package afr_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_VERSION = 4'd1,
    PH_SIZE    = 4'd2,
    PH_LEFT    = 4'd3,
    PH_ADDR    = 4'd4,
    PH_VALUE   = 4'd5,
    PH_RIGHT   = 4'd6,
    PH_DONE    = 4'd7,
    PH_ERROR   = 4'd8
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE   = 4'd0,
    REG_EXP_VERSION  = 4'd1,
    REG_MAX_SIZE     = 4'd2,
    REG_LEFT_DELIM   = 4'd3,
    REG_RIGHT_DELIM  = 4'd4,
    REG_ATTR_MARK    = 4'd5,
    REG_SEP_MARK     = 4'd6,
    REG_EOP_BYTE     = 4'd7
  } cfg_reg_t;

  localparam logic       OP_RECEIVE = 1'b0;
  localparam logic       OP_DROP    = 1'b1;

  localparam logic [7:0]  RST_START_BYTE  = 8'd2;
  localparam logic [23:0] RST_EXP_VERSION = 24'h010000;
  localparam logic [7:0]  RST_MAX_SIZE    = 8'd255;
  localparam logic [7:0]  RST_LEFT_DELIM  = 8'd123;
  localparam logic [7:0]  RST_RIGHT_DELIM = 8'd125;
  localparam logic [7:0]  RST_ATTR_MARK   = 8'd58;
  localparam logic [7:0]  RST_SEP_MARK    = 8'd44;
  localparam logic [7:0]  RST_EOP_BYTE    = 8'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       store_strobe;
    logic [7:0] store_byte;
    logic       frame_done;
    logic       in_error;
    logic       clear_buffer;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [23:0] expected_version;
    logic [7:0]  max_payload_size;
    logic [7:0]  left_delimiter;
    logic [7:0]  right_delimiter;
    logic [7:0]  attribute_mark;
    logic [7:0]  separator_mark;
    logic [7:0]  end_of_packet_byte;
  } cfg_regs_t;

endpackage

[sv/afr_cfg.sv]
// Configuration register file for the frame receiver.
// Depends on afr_pkg for register indexes and reset values.
module afr_cfg
  import afr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_regs_t             regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_byte         <= RST_START_BYTE;
      regs.expected_version   <= RST_EXP_VERSION;
      regs.max_payload_size   <= RST_MAX_SIZE;
      regs.left_delimiter     <= RST_LEFT_DELIM;
      regs.right_delimiter    <= RST_RIGHT_DELIM;
      regs.attribute_mark     <= RST_ATTR_MARK;
      regs.separator_mark     <= RST_SEP_MARK;
      regs.end_of_packet_byte <= RST_EOP_BYTE;
    end else if (cfg_valid && cfg_ready) begin
      // indexes past the last register are dropped
      unique case (cfg_index)
        REG_START_BYTE:  regs.start_byte         <= cfg_data[7:0];
        REG_EXP_VERSION: regs.expected_version   <= cfg_data;
        REG_MAX_SIZE:    regs.max_payload_size   <= cfg_data[7:0];
        REG_LEFT_DELIM:  regs.left_delimiter     <= cfg_data[7:0];
        REG_RIGHT_DELIM: regs.right_delimiter    <= cfg_data[7:0];
        REG_ATTR_MARK:   regs.attribute_mark     <= cfg_data[7:0];
        REG_SEP_MARK:    regs.separator_mark     <= cfg_data[7:0];
        REG_EOP_BYTE:    regs.end_of_packet_byte <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/afr_parser.sv]
// Frame parser: phase register, version capture and per-byte result logic.
// Depends on afr_pkg for the phase enum and payload structs.
module afr_parser
  import afr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_regs_t regs,
  output out_item_t res
);

  phase_t      phase, phase_next;
  logic [1:0]  version_count, version_count_next;
  logic [23:0] version_seen, version_seen_next;
  logic        size_ok;
  logic        version_ok;

  assign size_ok    = item.rx_byte <= regs.max_payload_size;
  assign version_ok = version_seen == regs.expected_version;

  // next state
  always_comb begin
    phase_next         = phase;
    version_count_next = version_count;
    version_seen_next  = version_seen;
    if (item.op == OP_DROP) begin
      phase_next         = PH_IDLE;
      version_count_next = 2'd0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (item.rx_byte == regs.start_byte) phase_next = PH_VERSION;
        end
        PH_VERSION: begin
          case (version_count)
            2'd0: version_seen_next[23:16] = item.rx_byte;
            2'd1: version_seen_next[15:8]  = item.rx_byte;
            2'd2: version_seen_next[7:0]   = item.rx_byte;
            default: ;
          endcase
          if (version_count != 2'd3) begin
            version_count_next = version_count + 2'd1;
          end else begin
            version_count_next = 2'd0;
            if (!version_ok)  phase_next = PH_ERROR;
            else if (size_ok) phase_next = PH_LEFT;
            else              phase_next = PH_SIZE;
          end
        end
        PH_SIZE: begin
          phase_next = size_ok ? PH_LEFT : PH_SIZE;
        end
        PH_LEFT: begin
          if (item.rx_byte == regs.left_delimiter) phase_next = PH_ADDR;
        end
        PH_ADDR: begin
          if (item.rx_byte == regs.attribute_mark)       phase_next = PH_VALUE;
          else if (item.rx_byte == regs.right_delimiter) phase_next = PH_RIGHT;
        end
        PH_VALUE: begin
          if (item.rx_byte == regs.separator_mark)       phase_next = PH_ADDR;
          else if (item.rx_byte == regs.right_delimiter) phase_next = PH_RIGHT;
        end
        PH_RIGHT: begin
          phase_next = (item.rx_byte == regs.end_of_packet_byte) ? PH_DONE : PH_ADDR;
        end
        default: ;
      endcase
    end
  end

  // result fields
  always_comb begin
    res              = '0;
    res.clear_buffer = item.op == OP_DROP;
    if (item.op == OP_RECEIVE) begin
      unique case (phase)
        PH_IDLE:    res.accepted = item.rx_byte == regs.start_byte;
        PH_VERSION: res.accepted = (version_count != 2'd3) || (version_ok && size_ok);
        PH_SIZE:    res.accepted = size_ok;
        PH_LEFT: begin
          res.accepted     = 1'b1;
          res.store_strobe = item.rx_byte == regs.left_delimiter;
        end
        PH_ADDR, PH_VALUE: begin
          res.accepted     = 1'b1;
          res.store_strobe = 1'b1;
        end
        PH_RIGHT: begin
          res.accepted     = 1'b1;
          res.store_strobe = 1'b1;
          res.frame_done   = item.rx_byte == regs.end_of_packet_byte;
        end
        default: ;
      endcase
    end
    res.store_byte = res.store_strobe ? item.rx_byte : 8'd0;
    res.in_error   = phase_next == PH_ERROR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      version_count <= 2'd0;
      version_seen  <= 24'd0;
    end else if (fire) begin
      phase         <= phase_next;
      version_count <= version_count_next;
      version_seen  <= version_seen_next;
    end
  end

  a_count_only_in_version: assert property (@(posedge clk) disable iff (rst)
    version_count != 2'd0 |-> phase == PH_VERSION)
    else $error("version count set outside version phase");

  a_drop_to_idle: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == OP_DROP |=> phase == PH_IDLE && version_count == 2'd0)
    else $error("drop did not return parser to idle");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    fire && res.frame_done |=> phase == PH_DONE)
    else $error("frame completion did not enter done phase");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR && !(fire && item.op == OP_DROP) |=> phase == PH_ERROR)
    else $error("error phase left without a drop");

endmodule

[sv/afr_out_buf.sv]
// Two-entry result buffer between the parser and the output channel.
// Depends on afr_pkg for the result struct.
module afr_out_buf
  import afr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign can_push  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2 && !(push && count == 2'd2))
    else $error("result buffer overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("buffer pointers disagree with count");

  a_pop_advances: assert property (@(posedge clk) disable iff (rst)
    pop |=> rd_ptr != $past(rd_ptr))
    else $error("read pointer did not advance on transfer");

endmodule

[sv/attribute_frame_receiver_top.sv]
// Attribute frame receiver, top level: config registers, parser, result buffer.
// Each result is registered in the result buffer and offered on out_valid behind any older one.
// Throughput: one byte per cycle; the two-entry result buffer keeps input open
// while one result waits, and in_ready drops only when both entries are full.
// Reset (rst, synchronous): parser idle, version capture cleared, buffer empty,
// config registers back to their default values.
module attribute_frame_receiver_top
  import afr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t regs;
  out_item_t res;
  logic      fire;

  assign fire = in_valid && in_ready;

  afr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  afr_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_data),
    .regs (regs),
    .res  (res)
  );

  afr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[verif/tb_attribute_frame_receiver_top.sv]
// Testbench for attribute_frame_receiver_top: directed and random byte streams
// checked against a local frame parser model. Depends on afr_pkg and the top level.
`timescale 1ns / 100ps

module tb_attribute_frame_receiver_top;
  import afr_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  attribute_frame_receiver_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Parser model state and register copy
  cfg_regs_t   regs = '{RST_START_BYTE, RST_EXP_VERSION, RST_MAX_SIZE, RST_LEFT_DELIM,
                        RST_RIGHT_DELIM, RST_ATTR_MARK, RST_SEP_MARK, RST_EOP_BYTE};
  phase_t      frame_phase = PH_IDLE;
  logic [1:0]  ver_count = '0;
  logic [23:0] ver_seen = '0;

  in_item_t    rx_stream[$];
  out_item_t   parse_outcomes[$];
  int unsigned items_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned stall_draw;
  logic        no_gaps = 1'b0;
  logic        hold_out = 1'b0;
  out_item_t   want;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: if the run has not finished by this time, report FAIL and stop.
  initial begin
    #2_400_000;
    $display("tb_attribute_frame_receiver_top: FAIL");
    $finish;
  end

  function automatic out_item_t parse_byte(in_item_t it);
    out_item_t r;
    logic      size_byte;
    r = '0;
    size_byte = 1'b0;
    if (it.op == OP_DROP) begin
      frame_phase = PH_IDLE;
      ver_count = '0;
      r.clear_buffer = 1'b1;
    end else begin
      case (frame_phase)
        PH_IDLE: begin
          if (it.rx_byte == regs.start_byte) begin
            frame_phase = PH_VERSION;
            r.accepted = 1'b1;
          end
        end
        PH_VERSION: begin
          if (ver_count < 2'd3) begin
            ver_seen[23 - 8*int'(ver_count) -: 8] = it.rx_byte;
            ver_count = ver_count + 2'd1;
            r.accepted = 1'b1;
          end else begin
            ver_count = '0;
            if (ver_seen == regs.expected_version) size_byte = 1'b1;
            else frame_phase = PH_ERROR;
          end
        end
        PH_SIZE: size_byte = 1'b1;
        PH_LEFT: begin
          r.accepted = 1'b1;
          if (it.rx_byte == regs.left_delimiter) begin
            r.store_strobe = 1'b1;
            frame_phase = PH_ADDR;
          end
        end
        PH_ADDR: begin
          r.accepted = 1'b1;
          r.store_strobe = 1'b1;
          if (it.rx_byte == regs.attribute_mark) frame_phase = PH_VALUE;
          else if (it.rx_byte == regs.right_delimiter) frame_phase = PH_RIGHT;
        end
        PH_VALUE: begin
          r.accepted = 1'b1;
          r.store_strobe = 1'b1;
          if (it.rx_byte == regs.separator_mark) frame_phase = PH_ADDR;
          else if (it.rx_byte == regs.right_delimiter) frame_phase = PH_RIGHT;
        end
        PH_RIGHT: begin
          r.accepted = 1'b1;
          r.store_strobe = 1'b1;
          if (it.rx_byte == regs.end_of_packet_byte) begin
            frame_phase = PH_DONE;
            r.frame_done = 1'b1;
          end else begin
            frame_phase = PH_ADDR;
          end
        end
        default: ;
      endcase
      // oversize leaves the parser waiting for another size byte
      if (size_byte) begin
        if (it.rx_byte <= regs.max_payload_size) begin
          frame_phase = PH_LEFT;
          r.accepted = 1'b1;
        end else begin
          frame_phase = PH_SIZE;
        end
      end
    end
    r.store_byte = r.store_strobe ? it.rx_byte : 8'd0;
    r.in_error = (frame_phase == PH_ERROR);
    return r;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned exp_val);
    $display("result %0d: %s mismatch, got %0h want %0h", results_seen, what, got, exp_val);
    mismatch_count++;
  endtask

  // Input side: one gap drawn per byte, payload held until the transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_outcomes.push_back(parse_byte(in_data));
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (rx_stream.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= rx_stream.pop_front();
          send_gap <= no_gaps ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: compare each transfer with the oldest outcome, then stall
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      stall_draw = recv_stall;
      if (out_valid && out_ready) begin
        if (parse_outcomes.size() == 0) begin
          flag_mismatch("unexpected result", out_data, 0);
        end else begin
          want = parse_outcomes.pop_front();
          if (out_data.accepted !== want.accepted)
            flag_mismatch("accepted", out_data.accepted, want.accepted);
          if (out_data.store_strobe !== want.store_strobe)
            flag_mismatch("store_strobe", out_data.store_strobe, want.store_strobe);
          if (out_data.store_byte !== want.store_byte)
            flag_mismatch("store_byte", out_data.store_byte, want.store_byte);
          if (out_data.frame_done !== want.frame_done)
            flag_mismatch("frame_done", out_data.frame_done, want.frame_done);
          if (out_data.in_error !== want.in_error)
            flag_mismatch("in_error", out_data.in_error, want.in_error);
          if (out_data.clear_buffer !== want.clear_buffer)
            flag_mismatch("clear_buffer", out_data.clear_buffer, want.clear_buffer);
        end
        results_seen++;
        stall_draw = no_gaps ? 0 : $urandom_range(0, 6);
      end
      if (hold_out) begin
        out_ready <= 1'b0;
        recv_stall <= stall_draw;
      end else if (stall_draw != 0) begin
        out_ready <= 1'b0;
        recv_stall <= stall_draw - 1;
      end else begin
        out_ready <= 1'b1;
        recv_stall <= 0;
      end
    end
  end

  // Long receiver hold-off mid-run so the result buffer fills and input stalls
  initial begin
    wait (bytes_taken >= 150);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (60) @(posedge clk);
    hold_out <= 1'b0;
  end

  task automatic push_byte(logic [7:0] b);
    rx_stream.push_back('{op: OP_RECEIVE, rx_byte: b});
    items_queued++;
  endtask

  task automatic push_drop();
    rx_stream.push_back('{op: OP_DROP, rx_byte: 8'($urandom)});
    items_queued++;
  endtask

  function automatic logic [7:0] other_than(logic [7:0] a, logic [7:0] c);
    logic [7:0] v;
    do v = 8'($urandom); while (v == a || v == c);
    return v;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_BYTE:  regs.start_byte = val[7:0];
      REG_EXP_VERSION: regs.expected_version = val;
      REG_MAX_SIZE:    regs.max_payload_size = val[7:0];
      REG_LEFT_DELIM:  regs.left_delimiter = val[7:0];
      REG_RIGHT_DELIM: regs.right_delimiter = val[7:0];
      REG_ATTR_MARK:   regs.attribute_mark = val[7:0];
      REG_SEP_MARK:    regs.separator_mark = val[7:0];
      REG_EOP_BYTE:    regs.end_of_packet_byte = val[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(cfg_regs_t s);
    write_reg(REG_START_BYTE, 24'(s.start_byte));
    write_reg(REG_EXP_VERSION, s.expected_version);
    write_reg(REG_MAX_SIZE, 24'(s.max_payload_size));
    write_reg(REG_LEFT_DELIM, 24'(s.left_delimiter));
    write_reg(REG_RIGHT_DELIM, 24'(s.right_delimiter));
    write_reg(REG_ATTR_MARK, 24'(s.attribute_mark));
    write_reg(REG_SEP_MARK, 24'(s.separator_mark));
    write_reg(REG_EOP_BYTE, 24'(s.end_of_packet_byte));
    // unmapped index, must be ignored
    write_reg(4'(REG_EOP_BYTE) + 4'($urandom_range(1, 8)), 24'($urandom));
  endtask

  task automatic settle();
    while (rx_stream.size() != 0 || in_valid || parse_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; some bad versions,
  // oversize bytes, missing end of packet, and stray noise in between.
  task automatic queue_traffic(int unsigned goal);
    logic [23:0] ver;
    int unsigned n_attr;
    while (items_queued < goal) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 7) == 0) push_drop();
          else if ($urandom_range(0, 3) == 0) push_byte(regs.start_byte);
          else push_byte(8'($urandom));
        end
        if ($urandom_range(0, 1) == 0) push_drop();
      end else begin
        push_byte(regs.start_byte);
        ver = regs.expected_version;
        if ($urandom_range(0, 9) == 0) ver = ver ^ 24'($urandom_range(1, 24'hFFFFFF));
        push_byte(ver[23:16]);
        push_byte(ver[15:8]);
        push_byte(ver[7:0]);
        if (regs.max_payload_size != 8'hFF && $urandom_range(0, 3) == 0)
          push_byte(8'($urandom_range(int'(regs.max_payload_size) + 1, 255)));
        push_byte(8'($urandom_range(0, int'(regs.max_payload_size))));
        repeat ($urandom_range(0, 2)) push_byte(other_than(regs.left_delimiter,
                                                           regs.left_delimiter));
        push_byte(regs.left_delimiter);
        n_attr = $urandom_range(0, 4);
        for (int unsigned k = 0; k < n_attr; k++) begin
          if (k != 0) push_byte(regs.separator_mark);
          repeat ($urandom_range(1, 3))
            push_byte(other_than(regs.attribute_mark, regs.right_delimiter));
          push_byte(regs.attribute_mark);
          repeat ($urandom_range(1, 3))
            push_byte(other_than(regs.separator_mark, regs.right_delimiter));
        end
        push_byte(regs.right_delimiter);
        if ($urandom_range(0, 4) == 0) begin
          push_byte(other_than(regs.end_of_packet_byte, regs.end_of_packet_byte));
          push_byte(other_than(regs.attribute_mark, regs.right_delimiter));
          push_byte(regs.right_delimiter);
        end
        if ($urandom_range(0, 7) != 0) push_byte(regs.end_of_packet_byte);
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
        push_drop();
      end
    end
  endtask

  initial begin
    cfg_regs_t s;
    wait (rst == 1'b0);

    // Directed: reset settings, one complete frame then a version mismatch
    push_byte(8'hFF);                       // idle, not the start byte
    push_drop();                            // drop while idle
    push_byte(regs.start_byte);
    push_byte(regs.expected_version[23:16]);
    push_byte(regs.expected_version[15:8]);
    push_byte(regs.expected_version[7:0]);
    push_byte(8'hFF);                       // size at the maximum
    push_byte(8'h00);                       // before left delimiter: taken, not stored
    push_byte(regs.left_delimiter);
    push_byte(8'h61);
    push_byte(regs.attribute_mark);
    push_byte(8'hFF);
    push_byte(regs.separator_mark);
    push_byte(8'h62);
    push_byte(regs.right_delimiter);        // closes the list from an address
    push_byte(8'h78);                       // not end of packet: back to address
    push_byte(regs.right_delimiter);
    push_byte(regs.end_of_packet_byte);
    push_byte(regs.start_byte);             // after completion: rejected
    push_drop();
    push_byte(regs.start_byte);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);                       // size byte with wrong version
    push_drop();

    for (int unsigned pass_idx = 0; pass_idx < 7; pass_idx++) begin
      if (pass_idx != 0) begin
        settle();
        case (pass_idx)
          1: s = '0;
          2: s = '1;
          default: begin
            s = cfg_regs_t'({$urandom, $urandom, 16'($urandom)});
            if (pass_idx % 2 == 0) begin
              s.left_delimiter = RST_LEFT_DELIM;
              s.right_delimiter = RST_RIGHT_DELIM;
              s.attribute_mark = RST_ATTR_MARK;
              s.separator_mark = RST_SEP_MARK;
              s.end_of_packet_byte = RST_EOP_BYTE;
            end
          end
        endcase
        load_settings(s);
        no_gaps <= (pass_idx % 3 == 2);
      end
      queue_traffic(26 + 107 * (pass_idx + 1));
    end

    settle();
    if (parse_outcomes.size() != 0) flag_mismatch("missing results", 0, parse_outcomes.size());
    if (mismatch_count == 0) begin
      $display("tb_attribute_frame_receiver_top: PASS");
    end else begin
      $display("tb_attribute_frame_receiver_top: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/afr_pkg.sv
sv/afr_cfg.sv
sv/afr_parser.sv
sv/afr_out_buf.sv
sv/attribute_frame_receiver_top.sv
verif/tb_attribute_frame_receiver_top.sv
